// ===== rtl/capacitive_touch_bandpass_detector_core_assert.svh =====
// Assertion macros shared by the capacitive touch detector RTL
`ifndef CAPACITIVE_TOUCH_BANDPASS_DETECTOR_CORE_ASSERT_SVH
`define CAPACITIVE_TOUCH_BANDPASS_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CTBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CTBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ctbd_pkg.sv =====
// Shared constants, types and the moving-average function
package ctbd_pkg;

  localparam int unsigned SampleW = 15;
  localparam int unsigned AvgW    = 16;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  localparam int unsigned SlowShift = 6;
  localparam int unsigned FastShift = 3;
  localparam int unsigned ActShift  = 3;

  localparam logic [ThrW-1:0] ThresholdReset = 16'd8;

  typedef struct packed {
    logic                   presence;
    logic signed [AvgW-1:0] bandpass_value;
    logic [AvgW-1:0]        activity_level;
  } result_t;

  // ((2^k - 1) * avg + x) >> k, hot start when avg is zero
  function automatic logic [AvgW-1:0] ema(input logic [AvgW-1:0] avg,
                                          input logic [AvgW-1:0] x,
                                          input int unsigned k);
    logic [AvgW+SlowShift:0] acc;
    acc = (({(SlowShift+1)'(0), avg}) << k) - {(SlowShift+1)'(0), avg}
          + {(SlowShift+1)'(0), x};
    if (avg == '0) begin
      return x;
    end
    return AvgW'(acc >> k);
  endfunction

endpackage

// ===== rtl/capacitive_touch_bandpass_detector_core.sv =====
// Top level: stream input register, detector datapath, output register
// An accepted input request reaches m_tvalid via the input register and the output register.
// Throughput: one sample per clock while m_tready is high; the datapath updates all averages at once.
// While a result waits a new sample still enters an empty input register; s_tready
// drops only when both stages hold an item and m_tready is low.
// Reset (rst, synchronous): averages, previous bandpass and presence cleared,
// threshold set to 8, both stream stages emptied.
module capacitive_touch_bandpass_detector_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ctbd_pkg::InDataW-1:0]    s_tdata,   // [14:0] sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ctbd_pkg::OutDataW-1:0]   m_tdata,   // [0] presence, [16:1] bandpass_value,
                                                     // [32:17] activity_level
  input  logic                            cfg_wen,
  input  logic [ctbd_pkg::ThrW-1:0]       cfg_wdata
);
  import ctbd_pkg::*;

  logic               in_valid;
  logic [SampleW-1:0] in_sample;
  logic [ThrW-1:0]    threshold;
  logic               load;
  result_t            res;
  result_t            out_res;

  assign load     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_wen) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SampleW-1:0];
    end
  end

  ctbd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .en        (load),
    .sample    (in_sample),
    .threshold (threshold),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.activity_level, out_res.bandpass_value, out_res.presence};

`include "capacitive_touch_bandpass_detector_core_assert.svh"

  `CTBD_ASSERT_NXT(a_input_kept, clk, rst, in_valid && !load, in_valid)
  `CTBD_ASSERT_IMP(a_ready_when_out_free, clk, rst, !m_tvalid, s_tready)
  `CTBD_ASSERT_NXT(a_load_gives_result, clk, rst, load, m_tvalid)

endmodule

// ===== rtl/ctbd_datapath.sv =====
// Averaging state and combinational update of the bandpass detector
module ctbd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [ctbd_pkg::SampleW-1:0]      sample,
  input  logic [ctbd_pkg::ThrW-1:0]         threshold,
  output ctbd_pkg::result_t                 res
);
  import ctbd_pkg::*;

  logic [AvgW-1:0]        slow_avg, slow_avg_next;
  logic [AvgW-1:0]        fast_avg, fast_avg_next;
  logic [AvgW-1:0]        act_avg, act_avg_next;
  logic signed [AvgW-1:0] prev_bp;
  logic                   presence, presence_next;

  logic [AvgW-1:0]        x;
  logic signed [AvgW:0]   bp_wide;
  logic signed [AvgW+1:0] diff;
  logic [AvgW-1:0]        delta;

  always_comb begin
    x             = {1'b0, sample};
    slow_avg_next = ema(slow_avg, x, SlowShift);
    fast_avg_next = ema(fast_avg, x, FastShift);
    bp_wide       = $signed({1'b0, slow_avg_next}) - $signed({1'b0, fast_avg_next});
    diff          = {bp_wide[AvgW], bp_wide} - {{2{prev_bp[AvgW-1]}}, prev_bp};
    delta         = diff[AvgW+1] ? AvgW'(-diff) : AvgW'(diff);
    act_avg_next  = ema(act_avg, delta, ActShift);
    presence_next = presence;
    if (act_avg_next > threshold) begin
      presence_next = (x < slow_avg_next);
    end
    res.presence       = presence_next;
    res.bandpass_value = bp_wide[AvgW-1:0];
    res.activity_level = act_avg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_avg <= '0;
      fast_avg <= '0;
      act_avg  <= '0;
      prev_bp  <= '0;
      presence <= 1'b0;
    end else if (en) begin
      slow_avg <= slow_avg_next;
      fast_avg <= fast_avg_next;
      act_avg  <= act_avg_next;
      prev_bp  <= bp_wide[AvgW-1:0];
      presence <= presence_next;
    end
  end

`include "capacitive_touch_bandpass_detector_core_assert.svh"

  `CTBD_ASSERT_NXT(a_presence_hold, clk, rst, en && (act_avg_next <= threshold), presence == $past(presence))
  `CTBD_ASSERT_NXT(a_slow_hot_start, clk, rst, en && (slow_avg == '0), slow_avg == $past(x))
  `CTBD_ASSERT_NXT(a_fast_hot_start, clk, rst, en && (fast_avg == '0), fast_avg == $past(x))

endmodule
